FILE: src/knn_pkg.sv
package knn_pkg;
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam int unsigned NUM_FEAT   = 8;
  localparam int unsigned FEAT_W     = 16;
  localparam int unsigned LABEL_W    = 5;
  localparam int unsigned CNT_W      = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'b0;

  typedef struct packed {
    logic [LABEL_W-1:0] pred;
    logic               ok;
    logic [CNT_W-1:0]   correct_total;
    logic [CNT_W-1:0]   tested_total;
  } result_t;
endpackage

FILE: src/knn_majority_vote_classifier_unit.sv
// Load and clear: one transfer per cycle while no result waits. Classify: per stored sample,
// one feature read and multiply-accumulate per cycle, a pipeline drain and an insert,
// plus one neighbor-list shift per place the sample moves up, up to k-1 shifts; then
// tallying of the neighbors, a winner search over NUM_LABELS and registering the result.
// One item at a time; not ready meanwhile, nor while a result waits.
// Reset clears count, counters, k=1 and control; the sample store is not cleared.
module knn_majority_vote_classifier_unit import knn_pkg::*; #(
  parameter int unsigned MAX_TRAIN   = 1024,
  parameter int unsigned FEATURES    = 8,
  parameter int unsigned NUM_LABELS  = 30,
  parameter int unsigned MAX_K       = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[1:0], feature_0..feature_7 [16 each], class_label[5], zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // predicted_label[5], correct[1], correct_total[16], tested_total[16], zero fill
  output logic [39:0]  m_axis_tdata
);
  localparam int unsigned IDX_W  = $clog2(MAX_TRAIN);
  localparam int unsigned CNT_SW = $clog2(MAX_TRAIN + 1);
  localparam int unsigned FI_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned K_W    = $clog2(MAX_K + 1);
  localparam int unsigned KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned LB_W   = $clog2(NUM_LABELS);
  localparam int unsigned VOTE_W = K_W;
  localparam int unsigned DIST_W = 2*SAMPLE_BITS + $clog2(FEATURES + 1);
  localparam int unsigned WORD_W = FEATURES*SAMPLE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0, S_FEAT = 3'd1, S_DRAIN = 3'd2,
                         S_INS = 3'd3, S_TALLY = 3'd4, S_WIN = 3'd5, S_OUT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] k_reg_q;
  logic [CNT_SW-1:0] count_q;
  logic [CNT_W-1:0] corr_q, test_q;

  // one word per stored sample, all features side by side
  logic [WORD_W-1:0]      fmem [MAX_TRAIN];
  logic [LABEL_W-1:0]     lmem [MAX_TRAIN];
  logic [WORD_W-1:0]      ld_word;
  logic [WORD_W-1:0]      frd_q;
  logic [LABEL_W-1:0]     lrd_q;

  logic [SAMPLE_BITS-1:0] q_feat_q [FEATURES];
  logic [LABEL_W-1:0]     q_label_q;
  logic [IDX_W-1:0]       samp_q;
  logic [FI_W-1:0]        fi_q, fi_d1_q;
  logic [1:0]             drain_q;
  logic                   mac_en_q;

  logic [DIST_W-1:0]  bd_q [MAX_K];
  logic [LABEL_W-1:0] bl_q [MAX_K];
  logic [K_W-1:0]     k_eff_q, filled_q, pos_q;
  logic [VOTE_W-1:0]  tally_q [NUM_LABELS];
  logic [K_W-1:0]     ti_q;
  logic [LB_W:0]      li_q;
  logic [LB_W-1:0]    win_q;
  logic [VOTE_W-1:0]  winv_q;
  logic [DIST_W-1:0]  dist_sum;
  logic               dist_clr;
  result_t            res_q;
  logic               out_vld_q;

  logic wr_en, in_acc;
  logic [1:0] in_op;
  logic [K_W-1:0] k_clamp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_NEIGHBOR_COUNT);
  assign prdata = (paddr[2] == REG_NEIGHBOR_COUNT) ? {26'd0, k_reg_q} : 32'd0;
  assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = s_axis_tdata[1:0];

  always_comb begin
    logic [6:0] kk;
    kk = {1'b0, k_reg_q};
    if (kk == 7'd0) kk = 7'd1;
    if (kk > 7'(MAX_K)) kk = 7'(MAX_K);
    if (CNT_SW'(kk) > count_q) k_clamp = K_W'(count_q);
    else k_clamp = K_W'(kk);
  end

  knn_dist #(.SAMPLE_BITS(SAMPLE_BITS), .DIST_W(DIST_W)) u_dist (
    .clk_i, .clr_i(dist_clr), .en_i(mac_en_q),
    .a_i(q_feat_q[fi_d1_q]), .b_i(frd_q[fi_d1_q*SAMPLE_BITS +: SAMPLE_BITS]),
    .sum_o(dist_sum)
  );
  // sum must hold through every insertion cycle of a sample
  assign dist_clr = (state_q == S_IDLE) || (state_q == S_INS && state_d != S_INS);

  always_comb begin
    for (int f = 0; f < FEATURES; f++)
      ld_word[f*SAMPLE_BITS +: SAMPLE_BITS] = s_axis_tdata[2+16*f +: SAMPLE_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == OP_LOAD && count_q < CNT_SW'(MAX_TRAIN)) begin
      fmem[count_q[IDX_W-1:0]] <= ld_word;
      lmem[count_q[IDX_W-1:0]] <= s_axis_tdata[130 +: LABEL_W];
    end
    frd_q <= fmem[samp_q];
    lrd_q <= lmem[samp_q];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && in_op == OP_CLASSIFY)
                 state_d = (count_q == '0) ? S_TALLY : S_FEAT;
      S_FEAT:  if (fi_q == FI_W'(FEATURES-1)) state_d = S_DRAIN;
      S_DRAIN: if (drain_q == 2'd2) state_d = S_INS;
      S_INS: begin
        if (filled_q == k_eff_q && dist_sum >= bd_q[KI_W'(k_eff_q-1)])
          state_d = (CNT_SW'(samp_q) == count_q - 1'b1) ? S_TALLY : S_FEAT;
        else if (pos_q == '0 || bd_q[KI_W'(pos_q-1)] <= dist_sum)
          state_d = (CNT_SW'(samp_q) == count_q - 1'b1) ? S_TALLY : S_FEAT;
      end
      S_TALLY: if (ti_q == filled_q) state_d = S_WIN;
      S_WIN:   if (li_q == (LB_W+1)'(NUM_LABELS-1)) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; k_reg_q <= 6'd1; count_q <= '0;
      corr_q <= '0; test_q <= '0; out_vld_q <= 1'b0; mac_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mac_en_q <= (state_q == S_FEAT);
      if (wr_en) k_reg_q <= pwdata[5:0];
      if (in_acc && in_op == OP_LOAD && count_q < CNT_SW'(MAX_TRAIN))
        count_q <= count_q + 1'b1;
      if (in_acc && in_op == OP_CLEAR) begin
        count_q <= '0; corr_q <= '0; test_q <= '0;
      end
      if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
      if (state_q == S_OUT) begin
        out_vld_q <= 1'b1;
        if (res_q.ok && corr_q != CNT_MAX) corr_q <= corr_q + 1'b1;
        if (test_q != CNT_MAX) test_q <= test_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        for (int f = 0; f < FEATURES; f++) q_feat_q[f] <= s_axis_tdata[2+16*f +: SAMPLE_BITS];
        q_label_q <= s_axis_tdata[130 +: LABEL_W];
        samp_q <= '0; fi_q <= '0; drain_q <= '0;
        k_eff_q <= k_clamp; filled_q <= '0; ti_q <= '0; li_q <= '0;
        win_q <= '0; winv_q <= '0;
        for (int l = 0; l < NUM_LABELS; l++) tally_q[l] <= '0;
      end
      S_FEAT: begin
        fi_d1_q <= fi_q;
        fi_q <= (fi_q == FI_W'(FEATURES-1)) ? '0 : fi_q + 1'b1;
        drain_q <= '0;
      end
      S_DRAIN: begin
        drain_q <= drain_q + 1'b1;
        pos_q <= (filled_q < k_eff_q) ? filled_q : k_eff_q - 1'b1;
      end
      S_INS: begin
        if (!(filled_q == k_eff_q && dist_sum >= bd_q[KI_W'(k_eff_q-1)])) begin
          if (pos_q != '0 && bd_q[KI_W'(pos_q-1)] > dist_sum) begin
            bd_q[KI_W'(pos_q)] <= bd_q[KI_W'(pos_q-1)];
            bl_q[KI_W'(pos_q)] <= bl_q[KI_W'(pos_q-1)];
            pos_q <= pos_q - 1'b1;
          end else begin
            bd_q[KI_W'(pos_q)] <= dist_sum;
            bl_q[KI_W'(pos_q)] <= lrd_q;
            if (filled_q < k_eff_q) filled_q <= filled_q + 1'b1;
          end
        end
        if (state_d != S_INS) samp_q <= samp_q + 1'b1;
      end
      S_TALLY: begin
        if (ti_q != filled_q) begin
          if (bl_q[KI_W'(ti_q)] < LABEL_W'(NUM_LABELS))
            tally_q[LB_W'(bl_q[KI_W'(ti_q)])] <= tally_q[LB_W'(bl_q[KI_W'(ti_q)])] + 1'b1;
          ti_q <= ti_q + 1'b1;
        end
      end
      S_WIN: begin
        if (tally_q[LB_W'(li_q)] > winv_q) begin
          winv_q <= tally_q[LB_W'(li_q)];
          win_q <= LB_W'(li_q);
        end
        li_q <= li_q + 1'b1;
      end
      default: ;
    endcase
    if (state_q == S_OUT) begin
      res_q.pred <= LABEL_W'(win_q);
      res_q.ok <= (LABEL_W'(win_q) == q_label_q);
      res_q.correct_total <= (LABEL_W'(win_q) == q_label_q && corr_q != CNT_MAX) ?
                             corr_q + 1'b1 : corr_q;
      res_q.tested_total <= (test_q != CNT_MAX) ? test_q + 1'b1 : test_q;
    end else if (state_q == S_WIN) begin
      res_q.ok <= (LABEL_W'((tally_q[LB_W'(li_q)] > winv_q) ? LB_W'(li_q) : win_q) ==
                   q_label_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {2'd0, res_q.tested_total, res_q.correct_total, res_q.ok, res_q.pred};

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> filled_q <= k_eff_q) else $error("list overfilled");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> m_axis_tvalid) else $error("result lost");
endmodule

FILE: src/knn_dist.sv
// Squared distance accumulator: one feature per cycle through a single multiplier.
module knn_dist import knn_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned DIST_W = 35
) (
  input  logic                   clk_i,
  input  logic                   clr_i,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] a_i,
  input  logic [SAMPLE_BITS-1:0] b_i,
  output logic [DIST_W-1:0]      sum_o
);
  logic [SAMPLE_BITS-1:0]   diff;
  logic [2*SAMPLE_BITS-1:0] sq_q;
  logic                     sq_vld_q;
  logic [DIST_W-1:0]        sum_q;

  assign diff = (a_i >= b_i) ? a_i - b_i : b_i - a_i;

  always_ff @(posedge clk_i) begin
    sq_q     <= diff * diff;
    sq_vld_q <= en_i;
    if (clr_i) sum_q <= '0;
    else if (sq_vld_q) sum_q <= sum_q + DIST_W'(sq_q);
  end

  assign sum_o = sum_q;
endmodule

FILE: verif/knn_majority_vote_classifier_unit_test.sv
`timescale 1ns / 1ps

module knn_majority_vote_classifier_unit_test;
  import knn_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned LABEL_CNT   = 30;
  localparam int unsigned K_MAX       = 32;
  localparam int unsigned STALL_LIMIT = 400000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct {
    logic [LABEL_W-1:0] pred;
    logic               ok;
    logic [CNT_W-1:0]   correct_total;
    logic [CNT_W-1:0]   tested_total;
  } verdict_t;

  class knn_scoreboard;
    logic [FEAT_W-1:0]  feat_mem [STORE_DEPTH][NUM_FEAT];
    logic [LABEL_W-1:0] label_mem [STORE_DEPTH];
    int unsigned        n_stored;
    int unsigned        k_reg;
    logic [CNT_W-1:0]   n_correct;
    logic [CNT_W-1:0]   n_tested;
    verdict_t           pending [$];
    int unsigned        mismatches;

    function void reset_state();
      n_stored = 0; k_reg = 1; n_correct = '0; n_tested = '0;
      pending.delete(); mismatches = 0;
    endfunction

    function logic [LABEL_W-1:0] vote(logic [FEAT_W-1:0] q [NUM_FEAT]);
      longint unsigned  best_d [K_MAX];
      logic [LABEL_W-1:0] lab [K_MAX];
      int unsigned tally [LABEL_CNT];
      int unsigned k, filled, pos, win, wv;
      longint unsigned d, df;
      k = (k_reg == 0) ? 1 : k_reg;
      if (k > K_MAX) k = K_MAX;
      if (k > n_stored) k = n_stored;
      filled = 0;
      for (int j = 0; j < n_stored; j++) begin
        d = 0;
        for (int f = 0; f < NUM_FEAT; f++) begin
          df = (q[f] >= feat_mem[j][f]) ? q[f] - feat_mem[j][f] : feat_mem[j][f] - q[f];
          d += df * df;
        end
        if (filled == k && (k == 0 || d >= best_d[k-1])) continue;
        pos = (filled < k) ? filled : k - 1;
        while (pos > 0 && best_d[pos-1] > d) begin
          best_d[pos] = best_d[pos-1]; lab[pos] = lab[pos-1]; pos--;
        end
        best_d[pos] = d; lab[pos] = label_mem[j];
        if (filled < k) filled++;
      end
      foreach (tally[i]) tally[i] = 0;
      for (int j = 0; j < filled; j++) if (lab[j] < LABEL_CNT) tally[lab[j]]++;
      win = 0; wv = 0;
      for (int l = 0; l < LABEL_CNT; l++)
        if (tally[l] > wv) begin
          wv = tally[l]; win = l;
        end
      return win[LABEL_W-1:0];
    endfunction

    function void note_input(logic [135:0] td);
      logic [1:0] op;
      logic [FEAT_W-1:0] q [NUM_FEAT];
      logic [LABEL_W-1:0] cl;
      verdict_t v;
      op = td[1:0];
      for (int f = 0; f < NUM_FEAT; f++) q[f] = td[2+16*f +: 16];
      cl = td[130 +: 5];
      if (op == OP_LOAD) begin
        if (n_stored < STORE_DEPTH) begin
          feat_mem[n_stored] = q; label_mem[n_stored] = cl; n_stored++;
        end
      end else if (op == OP_CLEAR) begin
        n_stored = 0; n_correct = '0; n_tested = '0;
      end else if (op == OP_CLASSIFY) begin
        v.pred = vote(q);
        v.ok = (v.pred == cl);
        if (v.ok && n_correct != CNT_MAX) n_correct++;
        if (n_tested != CNT_MAX) n_tested++;
        v.correct_total = n_correct; v.tested_total = n_tested;
        pending = {pending, v};
      end
    endfunction

    function void check_result(logic [39:0] td);
      verdict_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", td);
        return;
      end
      e = pending.pop_front();
      if (td[4:0] !== e.pred || td[5] !== e.ok || td[21:6] !== e.correct_total ||
          td[37:22] !== e.tested_total || td[39:38] !== 2'b00) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp pred=%0d ok=%0d ct=%0d tt=%0d, got pred=%0d ok=%0d ct=%0d tt=%0d",
                   e.pred, e.ok, e.correct_total, e.tested_total,
                   td[4:0], td[5], td[21:6], td[37:22]);
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  knn_majority_vote_classifier_unit dut (.*);

  knn_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit stim_done = 1'b0;
  int unsigned idle_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 8);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic write_k(int unsigned k);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {REG_NEIGHBOR_COUNT, 2'b00}; pwdata <= k;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.k_reg = k & 6'h3f;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // valid stays high after a transfer; the next send replaces or briefly drops it, wait_drained drops it
  task automatic send(logic [1:0] op, logic [FEAT_W-1:0] f [NUM_FEAT], logic [4:0] cl);
    logic [135:0] td;
    td = '0;
    td[1:0] = op;
    for (int i = 0; i < NUM_FEAT; i++) td[2+16*i +: 16] = f[i];
    td[130 +: 5] = cl;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= td;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(td);
  endtask

  task automatic send_rand(logic [1:0] op, int cl_hi, int near);
    logic [FEAT_W-1:0] f [NUM_FEAT];
    for (int i = 0; i < NUM_FEAT; i++)
      f[i] = near ? 16'($urandom_range(0, 7)) : 16'($urandom);
    send(op, f, 5'($urandom_range(0, cl_hi)));
  endtask

  initial begin
    logic [FEAT_W-1:0] z [NUM_FEAT], o [NUM_FEAT];
    int ks [6];
    ks = '{0, 1, 3, 32, 63, 5};
    foreach (z[i]) begin
      z[i] = '0; o[i] = '1;
    end
    sb.reset_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty store, extremes, ties, unknown labels, clear, unused op
    send(OP_CLASSIFY, z, 5'd0);
    send(OP_CLASSIFY, o, 5'd31);
    send(OP_LOAD, z, 5'd7);
    send(OP_LOAD, o, 5'd29);
    send(OP_LOAD, z, 5'd3);
    send(OP_LOAD, o, 5'd31);
    send(OP_CLASSIFY, z, 5'd7);
    send(OP_CLASSIFY, o, 5'd29);
    wait_drained();
    write_k(3);
    send(OP_CLASSIFY, z, 5'd3);
    send(OP_CLASSIFY, o, 5'd29);
    send(OP_UNUSED, o, 5'd31);
    send(OP_CLASSIFY, o, 5'd0);
    wait_drained();
    write_k(0);
    send(OP_CLASSIFY, z, 5'd7);
    wait_drained();
    write_k(63);
    send(OP_CLASSIFY, o, 5'd3);
    send(OP_CLEAR, o, 5'd0);
    send(OP_CLASSIFY, o, 5'd0);
    wait_drained();

    // random phases, each with its own k
    for (int ph = 0; ph < 6; ph++) begin
      write_k(ks[ph]);
      if (ph == 5) quiet_phase = 1'b1;
      send(OP_CLEAR, z, 5'd0);
      for (int i = 0; i < 95; i++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) send_rand(OP_LOAD, (r < 5) ? 31 : 4, ph[0]);
        else if (r < 94) send_rand(OP_CLASSIFY, (r < 90) ? 4 : 31, ph[0]);
        else if (r < 97) send_rand(OP_UNUSED, 31, 0);
        else send_rand(OP_CLEAR, 31, 0);
      end
      wait_drained();
    end
    stim_done = 1'b1;
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
